### hdl/apjq_pkg.sv
// Shared types and constants for the aging priority job queue.
// No dependencies; used by every module of the block.
package apjq_pkg;

  localparam int QueueDepthDefault = 16;
  localparam int TypeBitsDefault   = 8;
  localparam int IdBitsDefault     = 16;
  localparam int PrioBits          = 16;
  localparam int StatusBits        = 2;
  localparam int KindBits          = 2;
  localparam int FifoDepth         = 2;

  localparam logic signed [PrioBits-1:0] PrioUrgent = -16'sd1;
  localparam logic signed [PrioBits-1:0] PrioMin    = 16'sh8000;

  typedef enum logic [KindBits-1:0] {
    KIND_POST   = 2'd0,
    KIND_FETCH  = 2'd1,
    KIND_TICK   = 2'd2,
    KIND_URGENT = 2'd3
  } kind_t;

  typedef enum logic [StatusBits-1:0] {
    ST_DONE    = 2'd0,
    ST_NOMATCH = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

endpackage

### hdl/apjq_front.sv
// Front end: takes requests, masks the fields to their working widths and
// pushes them into a small command FIFO. Depends on apjq_pkg.
module apjq_front import apjq_pkg::*; #(
  parameter int TYPE_BITS = TypeBitsDefault,
  parameter int ID_BITS   = IdBitsDefault
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [1:0]                 kind,
  input  logic [15:0]                job_id,
  input  logic [7:0]                 job_type,
  input  logic signed [15:0]         job_priority,
  input  logic [7:0]                 want_mask,
  output logic                       full,
  input  logic                       pop,
  output logic                       cmd_valid,
  output kind_t                      cmd_kind,
  output logic [ID_BITS-1:0]         cmd_id,
  output logic [TYPE_BITS-1:0]       cmd_type,
  output logic signed [PrioBits-1:0] cmd_prio,
  output logic [TYPE_BITS-1:0]       cmd_mask
);

  localparam int W = KindBits + ID_BITS + 2 * TYPE_BITS + PrioBits;

  logic [W-1:0] fifo [FifoDepth];
  logic         rd_ptr, wr_ptr;
  logic [1:0]   count;
  logic [W-1:0] wdata, rdata;
  logic [ID_BITS-1:0]   id_w;
  logic [TYPE_BITS-1:0] type_w, mask_w;

  // Fields narrower than the port are truncated; wider ones are zero-extended.
  always_comb begin
    id_w   = ID_BITS'({16'd0, job_id});
    type_w = TYPE_BITS'({24'd0, job_type});
    mask_w = TYPE_BITS'({24'd0, want_mask});
  end

  assign wdata = {kind, id_w, type_w, job_priority, mask_w};
  assign rdata = fifo[rd_ptr];
  assign full  = (count == 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd_kind  = kind_t'(rdata[W-1 -: KindBits]);
  assign cmd_id    = rdata[W-KindBits-1 -: ID_BITS];
  assign cmd_type  = rdata[TYPE_BITS+PrioBits+TYPE_BITS-1 -: TYPE_BITS];
  assign cmd_prio  = rdata[PrioBits+TYPE_BITS-1 -: PrioBits];
  assign cmd_mask  = rdata[TYPE_BITS-1:0];

  always_ff @(posedge clk) begin
    if (push) fifo[wr_ptr] <= wdata;
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

### hdl/apjq_back.sv
// Back end: the sorted shift-register queue. Every slot compares at once,
// so each command updates the queue at the edge that takes it. Depends on apjq_pkg.
module apjq_back import apjq_pkg::*; #(
  parameter int QUEUE_DEPTH = QueueDepthDefault,
  parameter int TYPE_BITS   = TypeBitsDefault,
  parameter int ID_BITS     = IdBitsDefault
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cmd_valid,
  input  kind_t                      cmd_kind,
  input  logic [ID_BITS-1:0]         cmd_id,
  input  logic [TYPE_BITS-1:0]       cmd_type,
  input  logic signed [PrioBits-1:0] cmd_prio,
  input  logic [TYPE_BITS-1:0]       cmd_mask,
  output logic                       done,
  output logic [1:0]                 status,
  output logic [15:0]                out_id,
  output logic [7:0]                 out_type,
  output logic signed [15:0]         out_priority,
  output logic [4:0]                 entries
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [ID_BITS-1:0]         s_id   [QUEUE_DEPTH];
  logic [TYPE_BITS-1:0]       s_type [QUEUE_DEPTH];
  logic signed [PrioBits-1:0] s_prio [QUEUE_DEPTH];
  logic [ID_BITS-1:0]         s_id_next   [QUEUE_DEPTH];
  logic [TYPE_BITS-1:0]       s_type_next [QUEUE_DEPTH];
  logic signed [PrioBits-1:0] s_prio_next [QUEUE_DEPTH];
  logic [CW-1:0] fill, fill_next;

  logic [QUEUE_DEPTH-1:0] occ, gt_hit, mask_hit, id_hit;
  logic [QUEUE_DEPTH-1:0] gt_first, mask_first, id_first;
  logic [QUEUE_DEPTH-1:0] gt_after, mask_after, id_after;
  logic [ID_BITS-1:0]         sel_id;
  logic [TYPE_BITS-1:0]       sel_type;
  logic signed [PrioBits-1:0] sel_prio;
  status_t st_next;

  // Per-slot compares; "after" marks the slots at or beyond the first hit.
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      occ[i]      = (CW'(i) < fill);
      gt_hit[i]   = occ[i] && (cmd_prio < s_prio[i]);
      mask_hit[i] = occ[i] && ((s_type[i] & cmd_mask) != '0);
      id_hit[i]   = occ[i] && (s_id[i] == cmd_id);
    end
    gt_after   = gt_hit   | (gt_hit   << 1);
    mask_after = mask_hit;
    id_after   = id_hit;
    gt_after   = gt_hit;
    for (int i = 1; i < QUEUE_DEPTH; i++) begin
      gt_after[i]   = gt_after[i]   | gt_after[i-1];
      mask_after[i] = mask_after[i] | mask_after[i-1];
      id_after[i]   = id_after[i]   | id_after[i-1];
    end
    gt_first   = gt_after   & ~(gt_after   << 1);
    mask_first = mask_after & ~(mask_after << 1);
    id_first   = id_after   & ~(id_after   << 1);
    sel_id   = '0;
    sel_type = '0;
    sel_prio = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if ((cmd_kind == KIND_FETCH ? mask_first[i] : id_first[i])) begin
        sel_id   = sel_id   | s_id[i];
        sel_type = sel_type | s_type[i];
        sel_prio = sel_prio | s_prio[i];
      end
    end
  end

  always_comb begin
    fill_next = fill;
    st_next   = ST_DONE;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      s_id_next[i]   = s_id[i];
      s_type_next[i] = s_type[i];
      s_prio_next[i] = s_prio[i];
    end
    case (cmd_kind)
      KIND_POST: begin
        if (fill == CW'(QUEUE_DEPTH)) begin
          st_next = ST_FULL;
        end else begin
          fill_next = fill + 1'b1;
          // Slots at or after the insert point shift back by one.
          for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if ((!gt_after[i] && i < QUEUE_DEPTH && CW'(i) == fill) || gt_first[i]) begin
              s_id_next[i]   = cmd_id;
              s_type_next[i] = cmd_type;
              s_prio_next[i] = cmd_prio;
            end else if (gt_after[i] && i > 0) begin
              s_id_next[i]   = s_id[i-1];
              s_type_next[i] = s_type[i-1];
              s_prio_next[i] = s_prio[i-1];
            end
          end
        end
      end
      KIND_FETCH: begin
        if (mask_after[QUEUE_DEPTH-1]) begin
          fill_next = fill - 1'b1;
          for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
            if (mask_after[i]) begin
              s_id_next[i]   = s_id[i+1];
              s_type_next[i] = s_type[i+1];
              s_prio_next[i] = s_prio[i+1];
            end
          end
        end else begin
          st_next = ST_NOMATCH;
        end
      end
      KIND_TICK: begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
          if (occ[i] && s_prio[i] != PrioMin) s_prio_next[i] = s_prio[i] - 1'b1;
        end
      end
      default: begin
        if (!id_after[QUEUE_DEPTH-1]) begin
          st_next = ST_NOMATCH;
        end else if (!sel_prio[PrioBits-1]) begin
          // Slots ahead of the match move back one; the match goes to the front.
          for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (i == 0) begin
              s_id_next[i]   = cmd_id;
              s_type_next[i] = sel_type;
              s_prio_next[i] = PrioUrgent;
            end else if (!id_after[i-1]) begin
              s_id_next[i]   = s_id[i-1];
              s_type_next[i] = s_type[i-1];
              s_prio_next[i] = s_prio[i-1];
            end else if (id_first[i]) begin
              s_id_next[i]   = s_id[i-1];
              s_type_next[i] = s_type[i-1];
              s_prio_next[i] = s_prio[i-1];
            end
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd_valid) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        s_id[i]   <= s_id_next[i];
        s_type[i] <= s_type_next[i];
        s_prio[i] <= s_prio_next[i];
      end
      status       <= st_next;
      out_id       <= (cmd_kind == KIND_FETCH && st_next == ST_DONE) ? 16'(sel_id) : '0;
      out_type     <= (cmd_kind == KIND_FETCH && st_next == ST_DONE) ? 8'(sel_type) : '0;
      out_priority <= (cmd_kind == KIND_FETCH && st_next == ST_DONE) ? sel_prio : '0;
      entries      <= 5'(fill_next);
    end
    if (rst) begin
      fill <= '0;
      done <= 1'b0;
    end else begin
      done <= cmd_valid;
      if (cmd_valid) fill <= fill_next;
    end
  end

endmodule

### hdl/aging_priority_job_queue_unit.sv
// Top level of the aging priority job queue: front end with a command FIFO
// feeding the sorted-queue back end. Depends on apjq_pkg, apjq_front, apjq_back.
//
// Usage: drive kind and the job fields with start high while busy is low;
// the request is taken at that clock edge. Kinds are post, fetch by type
// mask, aging tick and make-urgent by id. Every request yields exactly one
// result, shown on status, out_id, out_type, out_priority and entries for
// one cycle with done high; the receiver cannot stall it.
// A request passes first through the two-entry command FIFO, then through the
// back end, which compares all slots in parallel and registers the updated
// queue together with the result and done.
// Throughput is one request per cycle: the back end drains a command every
// cycle, so the FIFO never fills and busy stays low.
// Synchronous reset empties the queue and the FIFO; slot contents are not
// cleared, since only occupied slots are ever read.
module aging_priority_job_queue_unit import apjq_pkg::*; #(
  parameter int QUEUE_DEPTH = QueueDepthDefault,
  parameter int TYPE_BITS   = TypeBitsDefault,
  parameter int ID_BITS     = IdBitsDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         kind,
  input  logic [15:0]        job_id,
  input  logic [7:0]         job_type,
  input  logic signed [15:0] job_priority,
  input  logic [7:0]         want_mask,
  output logic               done,
  output logic [1:0]         status,
  output logic [15:0]        out_id,
  output logic [7:0]         out_type,
  output logic signed [15:0] out_priority,
  output logic [4:0]         entries
);

  logic cmd_valid;
  kind_t cmd_kind;
  logic [ID_BITS-1:0]         cmd_id;
  logic [TYPE_BITS-1:0]       cmd_type, cmd_mask;
  logic signed [PrioBits-1:0] cmd_prio;

  apjq_front #(.TYPE_BITS(TYPE_BITS), .ID_BITS(ID_BITS)) u_front (
    .clk, .rst, .push(start && !busy), .kind, .job_id, .job_type, .job_priority,
    .want_mask, .full(busy), .pop(cmd_valid), .cmd_valid, .cmd_kind, .cmd_id,
    .cmd_type, .cmd_prio, .cmd_mask
  );

  apjq_back #(.QUEUE_DEPTH(QUEUE_DEPTH), .TYPE_BITS(TYPE_BITS), .ID_BITS(ID_BITS)) u_back (
    .clk, .rst, .cmd_valid, .cmd_kind, .cmd_id, .cmd_type, .cmd_prio, .cmd_mask,
    .done, .status, .out_id, .out_type, .out_priority, .entries
  );

endmodule

### test/aging_priority_job_queue_unit_check.sv
// Checker for the aging priority job queue: watches accepted requests and done
// strobes, keeps its own copy of the sorted queue and compares every result.
// Depends on apjq_pkg.
`timescale 1ns / 100ps
module aging_priority_job_queue_unit_check import apjq_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic [1:0]         kind,
  input  logic [15:0]        job_id,
  input  logic [7:0]         job_type,
  input  logic signed [15:0] job_priority,
  input  logic [7:0]         want_mask,
  input  logic               done,
  input  logic [1:0]         status,
  input  logic [15:0]        out_id,
  input  logic [7:0]         out_type,
  input  logic signed [15:0] out_priority,
  input  logic [4:0]         entries,
  output int                 fail_count,
  output int                 pending
);

  localparam int Depth = 16;

  typedef struct packed {
    logic [1:0]         status;
    logic [15:0]        id;
    logic [7:0]         jtype;
    logic signed [15:0] prio;
    logic [4:0]         entries;
  } outcome_t;

  typedef struct packed {
    logic [15:0]        id;
    logic [7:0]         jtype;
    logic signed [15:0] prio;
  } job_t;

  job_t     jobs[$];
  outcome_t outcomes[$];

  function automatic outcome_t queue_apply(logic [1:0] k, logic [15:0] id, logic [7:0] ty,
                                           logic signed [15:0] pr, logic [7:0] mask);
    outcome_t r;
    job_t j;
    int pos;
    r = '0;
    case (kind_t'(k))
      KIND_POST: begin
        if (jobs.size() >= Depth) begin
          r.status = ST_FULL;
        end else begin
          pos = jobs.size();
          for (int i = 0; i < jobs.size(); i++)
            if (pr < jobs[i].prio) begin
              pos = i;
              break;
            end
          j.id = id; j.jtype = ty; j.prio = pr;
          jobs.insert(pos, j);
          r.status = ST_DONE;
        end
      end
      KIND_FETCH: begin
        r.status = ST_NOMATCH;
        for (int i = 0; i < jobs.size(); i++)
          if ((jobs[i].jtype & mask) != 0) begin
            r.id = jobs[i].id; r.jtype = jobs[i].jtype; r.prio = jobs[i].prio;
            jobs.delete(i);
            r.status = ST_DONE;
            break;
          end
      end
      KIND_TICK: begin
        r.status = ST_DONE;
        foreach (jobs[i])
          if (jobs[i].prio != PrioMin) jobs[i].prio = jobs[i].prio - 16'sd1;
      end
      default: begin
        r.status = ST_NOMATCH;
        for (int i = 0; i < jobs.size(); i++)
          if (jobs[i].id == id) begin
            r.status = ST_DONE;
            if (jobs[i].prio >= 0) begin
              j = jobs[i];
              j.prio = PrioUrgent;
              jobs.delete(i);
              jobs.insert(0, j);
            end
            break;
          end
      end
    endcase
    r.entries = 5'(jobs.size());
    return r;
  endfunction

  always @(posedge clk) begin
    outcome_t e, a;
    if (rst) begin
      jobs.delete();
      outcomes.delete();
      fail_count <= 0;
    end else begin
      // The result of a request can never arrive in its own accepting cycle.
      if (done) begin
        a = '{status, out_id, out_type, out_priority, entries};
        if (outcomes.size() == 0) begin
          $display("%0t: unexpected result %h", $time, a);
          fail_count <= fail_count + 1;
        end else begin
          e = outcomes.pop_front();
          if (a !== e) begin
            $display("%0t: expected st=%0d id=%h ty=%h pr=%0d n=%0d, got st=%0d id=%h ty=%h pr=%0d n=%0d",
                     $time, e.status, e.id, e.jtype, e.prio, e.entries,
                     a.status, a.id, a.jtype, a.prio, a.entries);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy)
        outcomes.insert(outcomes.size(),
                        queue_apply(kind, job_id, job_type, job_priority, want_mask));
    end
    pending <= outcomes.size();
  end

endmodule

### test/aging_priority_job_queue_unit_test.sv
// Testbench top for the aging priority job queue: drives directed and random
// requests with random gaps and gives the verdict. Depends on apjq_pkg, the
// block and aging_priority_job_queue_unit_check.
`timescale 1ns / 100ps
module aging_priority_job_queue_unit_test import apjq_pkg::*;;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         kind = '0;
  logic [15:0]        job_id = '0;
  logic [7:0]         job_type = '0;
  logic signed [15:0] job_priority = '0;
  logic [7:0]         want_mask = '0;
  logic               done;
  logic [1:0]         status;
  logic [15:0]        out_id;
  logic [7:0]         out_type;
  logic signed [15:0] out_priority;
  logic [4:0]         entries;
  int                 fail_count;
  int                 pending;
  logic [15:0]        recent_ids[$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  aging_priority_job_queue_unit dut (.*);
  aging_priority_job_queue_unit_check checker_i (.*);

  // Holds one request until accepted, then waits a random gap when gaps is set.
  task automatic send_request(kind_t k, logic [15:0] id, logic [7:0] ty,
                              logic signed [15:0] pr, logic [7:0] mask, bit gaps);
    int gap;
    start <= 1'b1;
    kind <= k; job_id <= id; job_type <= ty; job_priority <= pr; want_mask <= mask;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (k == KIND_POST) begin
      recent_ids.insert(recent_ids.size(), id);
      if (recent_ids.size() > 24) void'(recent_ids.pop_front());
    end
    gap = gaps ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic random_request(int bias);
    int r;
    logic [15:0] id;
    logic signed [15:0] pr;
    r = $urandom_range(0, 99);
    id = (recent_ids.size() > 0 && $urandom_range(0, 3) != 0)
         ? recent_ids[$urandom_range(0, recent_ids.size() - 1)]
         : 16'($urandom_range(0, 15));
    if ($urandom_range(0, 7) == 0) id = 16'($urandom);
    case ($urandom_range(0, 5))
      0: pr = 16'($urandom);
      1: pr = $urandom_range(0, 1) ? 16'sh8000 + 16'($urandom_range(0, 2)) : 16'sh7fff;
      default: pr = 16'($urandom_range(0, 8)) - 16'sd3;
    endcase
    if (r < bias)
      send_request(KIND_POST, id, 8'($urandom), pr, 8'($urandom), $urandom_range(0, 3) != 0);
    else if (r < 75)
      send_request(KIND_FETCH, 16'($urandom), 8'($urandom), 16'($urandom),
                   $urandom_range(0, 4) == 0 ? 8'($urandom) : 8'(1 << $urandom_range(0, 7)),
                   $urandom_range(0, 3) != 0);
    else if (r < 87)
      send_request(KIND_TICK, 16'($urandom), 8'($urandom), 16'($urandom), 8'($urandom),
                   $urandom_range(0, 3) != 0);
    else
      send_request(KIND_URGENT, id, 8'($urandom), 16'($urandom), 8'($urandom),
                   $urandom_range(0, 3) != 0);
  endtask

  initial begin
    int waited;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_request(KIND_FETCH, 16'h0000, 8'h00, 16'sd0, 8'hff, 1'b0);
    send_request(KIND_TICK, 16'hffff, 8'hff, 16'sh7fff, 8'h00, 1'b0);
    send_request(KIND_URGENT, 16'h0005, 8'h00, 16'sd0, 8'h00, 1'b0);
    send_request(KIND_POST, 16'hffff, 8'hff, 16'sh7fff, 8'h00, 1'b0);
    send_request(KIND_POST, 16'h0000, 8'h01, 16'sh8000, 8'h00, 1'b0);
    send_request(KIND_POST, 16'h0001, 8'h80, 16'sd0, 8'h00, 1'b0);
    send_request(KIND_POST, 16'h0002, 8'h80, 16'sd0, 8'h00, 1'b0);
    send_request(KIND_TICK, 16'h0000, 8'h00, 16'sd0, 8'h00, 1'b0);
    send_request(KIND_URGENT, 16'h0002, 8'h00, 16'sd0, 8'h00, 1'b0);
    send_request(KIND_URGENT, 16'h0000, 8'h00, 16'sd0, 8'h00, 1'b0);
    send_request(KIND_URGENT, 16'hffff, 8'h00, 16'sd0, 8'h00, 1'b0);
    send_request(KIND_FETCH, 16'h0000, 8'h00, 16'sd0, 8'h00, 1'b0);
    send_request(KIND_FETCH, 16'h0000, 8'h00, 16'sd0, 8'h80, 1'b0);
    for (int i = 0; i < 14; i++)
      send_request(KIND_POST, 16'h0007, 8'(1 << (i % 8)), 16'(i % 3), 8'h00, 1'b1);
    send_request(KIND_POST, 16'haaaa, 8'h55, 16'sd1, 8'h00, 1'b0);
    send_request(KIND_URGENT, 16'h0007, 8'h00, 16'sd0, 8'h00, 1'b0);
    send_request(KIND_FETCH, 16'h5555, 8'haa, 16'sh5555, 8'hff, 1'b0);
    // Alternate filling and draining phases so the full queue is reached often.
    for (int i = 0; i < 1950; i++)
      random_request((i / 150) % 2 == 0 ? 60 : 25);
    start <= 1'b0;
    waited = 0;
    while (pending != 0 && waited < 1000) begin
      @(posedge clk);
      waited++;
    end
    repeat (5) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("aging_priority_job_queue_unit_test: clean");
    else
      $display("aging_priority_job_queue_unit_test: errors");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("aging_priority_job_queue_unit_test: errors");
    $finish;
  end

endmodule
